### rtl/core/bms_ascii_frame_receiver_unit_macros.svh
// Assertion macros for the ASCII frame receiver checker.
// Needs a clk and an arst_n in scope where they are used.
`ifndef BMS_ASCII_FRAME_RECEIVER_UNIT_MACROS_SVH
`define BMS_ASCII_FRAME_RECEIVER_UNIT_MACROS_SVH

// Checked only out of reset.
`define BAFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BAFR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/bafr_pkg.sv
// Shared codes, constants and hex decode for the ASCII frame receiver.
// No dependencies; imported by the receiver and its checker.
`default_nettype none

package bafr_pkg;

	localparam logic [7:0] SOF_CHAR = 8'h7E;

	localparam logic KIND_NIBBLE = 1'b0;
	localparam logic KIND_END    = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_VERSION  = 3'd1;
	localparam logic [2:0] ST_HEADER   = 3'd2;
	localparam logic [2:0] ST_LENGTH   = 3'd3;
	localparam logic [2:0] ST_BODY     = 3'd4;
	localparam logic [2:0] ST_CHECKSUM = 3'd5;

	localparam logic [7:0] VER_MIN = 8'h20;
	localparam logic [7:0] VER_MAX = 8'h2F;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [7:0]  version;
		logic [7:0]  address;
		logic [7:0]  device;
		logic [7:0]  ret_code;
		logic [15:0] len_word;
	} hdr_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'h0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/bms_ascii_frame_receiver_unit.sv
// ASCII-hex battery reply frame receiver: byte in, info nibbles and frame status out.
// Depends on bafr_pkg.
`default_nettype none

//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | rx_byte
//  out     | out_valid / out_stall| kind, info_nibble, status, protocol_version,
//          |                      | unit_address, device_code, return_code,
//          |                      | info_count
//
// One word is taken every cycle while in_stall is low; its result, if any, is in the
// output register in the next cycle. in_stall rises only while that register holds a
// word that the sink is stalling, so throughput is set by the single output register.
// arst_n clears the frame state and the output valid at once; the next word is
// treated as the start byte of a fresh frame.

module bms_ascii_frame_receiver_unit #(
	parameter int MAX_INFO_CHARS = 4095
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [3:0]       info_nibble,
	output logic [2:0]       status,
	output logic [7:0]       protocol_version,
	output logic [7:0]       unit_address,
	output logic [7:0]       device_code,
	output logic [7:0]       return_code,
	output logic [11:0]      info_count
);
	import bafr_pkg::*;

	// Position runs up to the terminator, at most 17 + MAX_INFO_CHARS.
	localparam int POS_W = $clog2(MAX_INFO_CHARS + 18);

	// Frame state
	logic [POS_W-1:0] pos_q, pos_n;
	hdr_t             hdr_q, hdr_n;
	logic [15:0]      sum_q, sum_n;
	logic [15:0]      rchk_q, rchk_n;
	logic             hdr_inv_q, hdr_inv_n;
	logic             body_inv_q, body_inv_n;

	// Output register
	logic             out_valid_q;
	logic             kind_q;
	logic [3:0]       nib_q;
	logic [2:0]       status_q;
	hdr_t             res_hdr_q;

	logic             accept;
	hex_t             hex;
	logic [12:0]      pos13;
	logic [11:0]      len;
	logic [5:0]       len_sum;
	logic [3:0]       len_code;
	logic             ver_bad, len_bad, hdr_bad;
	logic [12:0]      body_end, chk_end;
	logic             emit_nib, emit_end;
	logic [2:0]       st;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign hex   = hex_decode(rx_byte);
	assign pos13 = 13'(pos_q);
	assign len   = hdr_q.len_word[11:0];

	// Length word check: top nibble is the negated sum of the three length nibbles.
	assign len_sum  = 6'(len[11:8]) + 6'(len[7:4]) + 6'(len[3:0]);
	assign len_code = 4'(6'd0 - len_sum);
	assign len_bad  = (len_code != hdr_q.len_word[15:12]) || (len > 12'(MAX_INFO_CHARS));
	assign ver_bad  = (hdr_q.version < VER_MIN) || (hdr_q.version > VER_MAX);
	assign hdr_bad  = ver_bad | hdr_inv_q | len_bad;

	assign body_end = 13'd13 + 13'(len);
	assign chk_end  = body_end + 13'd4;

	// Status in priority order
	always_comb begin
		if (ver_bad) begin
			st = ST_VERSION;
		end else if (hdr_inv_q) begin
			st = ST_HEADER;
		end else if (len_bad) begin
			st = ST_LENGTH;
		end else if (body_inv_q) begin
			st = ST_BODY;
		end else if (rchk_q != 16'(16'd0 - sum_q)) begin
			st = ST_CHECKSUM;
		end else begin
			st = ST_OK;
		end
	end

	// Next frame state for the word at the input
	always_comb begin
		pos_n      = pos_q;
		hdr_n      = hdr_q;
		sum_n      = sum_q;
		rchk_n     = rchk_q;
		hdr_inv_n  = hdr_inv_q;
		body_inv_n = body_inv_q;
		emit_nib   = 1'b0;
		emit_end   = 1'b0;
		if (pos13 == 13'd0) begin
			// start byte: flag anything but the start character
			hdr_inv_n = (rx_byte != SOF_CHAR);
			pos_n     = POS_W'(1);
		end else if (pos13 <= 13'd12) begin
			// header characters: a non-hex one shifts in as zero
			if (!hex.ok) begin
				hdr_inv_n = 1'b1;
			end
			hdr_n = hdr_t'({hdr_q[43:0], hex.val});
			sum_n = sum_q + 16'(rx_byte);
			pos_n = pos_q + POS_W'(1);
		end else if (hdr_bad) begin
			// bad header: count through byte 18, then close the frame
			if (pos13 >= 13'd17) begin
				emit_end = 1'b1;
			end else begin
				pos_n = pos_q + POS_W'(1);
			end
		end else if (pos13 < body_end) begin
			sum_n = sum_q + 16'(rx_byte);
			pos_n = pos_q + POS_W'(1);
			if (hex.ok) begin
				emit_nib = 1'b1;
			end else begin
				body_inv_n = 1'b1;
			end
		end else if (pos13 < chk_end) begin
			if (!hex.ok) begin
				body_inv_n = 1'b1;
			end
			rchk_n = {rchk_q[11:0], hex.val};
			pos_n  = pos_q + POS_W'(1);
		end else begin
			// terminator, taken whatever its value
			emit_end = 1'b1;
		end
		if (emit_end) begin
			pos_n      = '0;
			hdr_n      = '0;
			sum_n      = '0;
			rchk_n     = '0;
			hdr_inv_n  = 1'b0;
			body_inv_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			hdr_q      <= '0;
			sum_q      <= '0;
			rchk_q     <= '0;
			hdr_inv_q  <= 1'b0;
			body_inv_q <= 1'b0;
		end else if (accept) begin
			pos_q      <= pos_n;
			hdr_q      <= hdr_n;
			sum_q      <= sum_n;
			rchk_q     <= rchk_n;
			hdr_inv_q  <= hdr_inv_n;
			body_inv_q <= body_inv_n;
		end
	end

	// Output valid: set on a new result, drop once the sink has taken it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && (emit_nib || emit_end)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: hold while stalled, zero the fields the kind does not use
	always_ff @(posedge clk) begin
		if (accept && (emit_nib || emit_end)) begin
			kind_q <= emit_end ? KIND_END : KIND_NIBBLE;
			if (emit_end) begin
				nib_q     <= 4'h0;
				status_q  <= st;
				res_hdr_q <= hdr_q;
			end else begin
				nib_q     <= hex.val;
				status_q  <= ST_OK;
				res_hdr_q <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = kind_q;
	assign info_nibble      = nib_q;
	assign status           = status_q;
	assign protocol_version = res_hdr_q.version;
	assign unit_address     = res_hdr_q.address;
	assign device_code      = res_hdr_q.device;
	assign return_code      = res_hdr_q.ret_code;
	assign info_count       = res_hdr_q.len_word[11:0];

endmodule

`default_nettype wire

### rtl/core/bafr_checker.sv
// Port-level checks for the ASCII frame receiver, bound to its top level.
// Depends on bafr_pkg and bms_ascii_frame_receiver_unit_macros.svh.
`default_nettype none

`include "bms_ascii_frame_receiver_unit_macros.svh"

module bafr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  rx_byte,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        kind,
	input wire logic [3:0]  info_nibble,
	input wire logic [2:0]  status,
	input wire logic [7:0]  protocol_version,
	input wire logic [7:0]  unit_address,
	input wire logic [7:0]  device_code,
	input wire logic [7:0]  return_code,
	input wire logic [11:0] info_count
);
	import bafr_pkg::*;

	// hold a stalled result word: kind, nibble, status, version and count
	`BAFR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable({kind, info_nibble, status, protocol_version, info_count}), "stalled result changed")
	// hold a stalled input word
	`BAFR_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(rx_byte), "stalled input changed")
	// stall the input only behind a blocked result
	`BAFR_ASSERT(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a blocked result")
	// nibble words carry no status or header
	`BAFR_ASSERT(a_nib_clean, out_valid && kind == KIND_NIBBLE |-> ({status, protocol_version, unit_address, device_code, return_code, info_count} == '0), "nibble word with header bits")
	// drop the output during reset
	`BAFR_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind bms_ascii_frame_receiver_unit bafr_checker u_bafr_checker (.*);

`default_nettype wire

### verif/bms_ascii_frame_receiver_unit_tb.sv
// Self-checking testbench for the ASCII-hex battery reply frame receiver.
// Depends on bafr_pkg and bms_ascii_frame_receiver_unit; holds its own frame predictor.
`timescale 1ns / 100ps

import bafr_pkg::*;

// One result word as the receiver presents it, in port order.
typedef struct packed {
	logic        kind;
	logic [3:0]  info_nibble;
	logic [2:0]  status;
	logic [7:0]  protocol_version;
	logic [7:0]  unit_address;
	logic [7:0]  device_code;
	logic [7:0]  return_code;
	logic [11:0] info_count;
} frame_word_t;

// Tracks the frame byte by byte and queues the words the receiver should emit.
class frame_word_checker;
	localparam int MAX_INFO = 4095;

	frame_word_t predicted_words[$];
	int          errors;

	logic [12:0] byte_pos;
	hdr_t        hdr;
	logic [15:0] char_sum;
	logic [15:0] rx_sum;
	bit          hdr_err;
	bit          body_err;

	function new();
		errors = 0;
		clear();
	endfunction

	function void clear();
		byte_pos = '0;
		hdr      = '0;
		char_sum = '0;
		rx_sum   = '0;
		hdr_err  = 1'b0;
		body_err = 1'b0;
	endfunction

	function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
		v = 4'h0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
			return 1'b1;
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h61 + 8'd10);
			return 1'b1;
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h41 + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function bit version_bad();
		return hdr.version < VER_MIN || hdr.version > VER_MAX;
	endfunction

	function bit length_bad();
		logic [11:0] n;
		logic [3:0]  s;
		logic [3:0]  code;
		n    = hdr.len_word[11:0];
		s    = n[11:8] + n[7:4] + n[3:0];
		code = 4'd0 - s;
		return (hdr.len_word[15:12] != code) || (int'(n) > MAX_INFO);
	endfunction

	function void end_frame();
		frame_word_t w;
		w = '0;
		w.kind = KIND_END;
		if (version_bad())
			w.status = ST_VERSION;
		else if (hdr_err)
			w.status = ST_HEADER;
		else if (length_bad())
			w.status = ST_LENGTH;
		else if (body_err)
			w.status = ST_BODY;
		else if (rx_sum != (16'd0 - char_sum))
			w.status = ST_CHECKSUM;
		else
			w.status = ST_OK;
		w.protocol_version = hdr.version;
		w.unit_address     = hdr.address;
		w.device_code      = hdr.device;
		w.return_code      = hdr.ret_code;
		w.info_count       = hdr.len_word[11:0];
		predicted_words.push_back(w);
		clear();
	endfunction

	// Advance the frame state by one accepted byte.
	function void take_byte(input logic [7:0] b);
		logic [3:0]  v;
		bit          ok;
		int          n;
		frame_word_t w;
		if (byte_pos == 0) begin
			hdr_err  = (b != SOF_CHAR);
			byte_pos = 13'd1;
			return;
		end
		if (byte_pos <= 12) begin
			ok = hex_nibble(b, v);
			if (!ok)
				hdr_err = 1'b1;
			hdr      = {hdr[43:0], v};
			char_sum = char_sum + 16'(b);
			byte_pos = byte_pos + 13'd1;
			return;
		end
		if (version_bad() || hdr_err || length_bad()) begin
			if (byte_pos >= 17)
				end_frame();
			else
				byte_pos = byte_pos + 13'd1;
			return;
		end
		n = int'(hdr.len_word[11:0]);
		if (int'(byte_pos) < 13 + n) begin
			char_sum = char_sum + 16'(b);
			byte_pos = byte_pos + 13'd1;
			if (hex_nibble(b, v)) begin
				w = '0;
				w.kind        = KIND_NIBBLE;
				w.info_nibble = v;
				predicted_words.push_back(w);
			end else begin
				body_err = 1'b1;
			end
			return;
		end
		if (int'(byte_pos) < 17 + n) begin
			ok = hex_nibble(b, v);
			if (!ok)
				body_err = 1'b1;
			rx_sum   = {rx_sum[11:0], v};
			byte_pos = byte_pos + 13'd1;
			return;
		end
		end_frame();
	endfunction

	function void report(input string what, input frame_word_t e, input frame_word_t g);
		errors++;
		if (errors <= 10) begin
			$display("%0t: %s", $time, what);
			$display("  exp kind=%0d nib=%h st=%0d ver=%h adr=%h dev=%h ret=%h len=%0d",
				e.kind, e.info_nibble, e.status, e.protocol_version, e.unit_address,
				e.device_code, e.return_code, e.info_count);
			$display("  got kind=%0d nib=%h st=%0d ver=%h adr=%h dev=%h ret=%h len=%0d",
				g.kind, g.info_nibble, g.status, g.protocol_version, g.unit_address,
				g.device_code, g.return_code, g.info_count);
		end
	endfunction

	function void check_word(input frame_word_t got);
		frame_word_t exp;
		if (predicted_words.size() == 0) begin
			report("result word with nothing predicted", '0, got);
			return;
		end
		exp = predicted_words.pop_front();
		if (got.kind !== exp.kind || got.info_nibble !== exp.info_nibble
				|| got.status !== exp.status
				|| got.protocol_version !== exp.protocol_version
				|| got.unit_address !== exp.unit_address
				|| got.device_code !== exp.device_code
				|| got.return_code !== exp.return_code
				|| got.info_count !== exp.info_count)
			report("result word mismatch", exp, got);
	endfunction

	function int pending();
		return predicted_words.size();
	endfunction
endclass

module bms_ascii_frame_receiver_unit_tb;

	// Ways of breaking a frame on purpose; FAULT_NONE gives a clean reply.
	typedef enum int {
		FAULT_NONE,
		FAULT_HDR_CHAR,
		FAULT_LEN_CODE,
		FAULT_BODY_CHAR,
		FAULT_SUM_CHAR,
		FAULT_SUM_VALUE,
		FAULT_NOISE
	} frame_fault_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [3:0]  info_nibble;
	logic [2:0]  status;
	logic [7:0]  protocol_version;
	logic [7:0]  unit_address;
	logic [7:0]  device_code;
	logic [7:0]  return_code;
	logic [11:0] info_count;

	frame_word_checker sb = new();

	// Set for a stretch with no gaps on either side.
	bit quiet = 1'b0;
	int bytes_sent = 0;

	bms_ascii_frame_receiver_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.info_nibble      (info_nibble),
		.status           (status),
		.protocol_version (protocol_version),
		.unit_address     (unit_address),
		.device_code      (device_code),
		.return_code      (return_code),
		.info_count       (info_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#8_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Sample both channels at the edge; values seen here are the pre-edge ones,
	// so the word accepted and the payload read always belong together.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_byte(rx_byte);
			if (out_valid && !out_stall)
				sb.check_word({kind, info_nibble, status, protocol_version, unit_address,
					device_code, return_code, info_count});
		end
	end

	// Sink: hold off for a drawn number of cycles, then take one word.
	initial begin
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = quiet ? 0 : $urandom_range(0, 9);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(out_valid && !out_stall));
		end
	end

	function automatic bit is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
			|| (c >= 8'h61 && c <= 8'h66);
	endfunction

	// Upper or lower case at random for the letters.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_hex(c));
		return c;
	endfunction

	function automatic logic [7:0] non_sof();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == SOF_CHAR);
		return c;
	endfunction

	// Offer one word after a drawn gap and hold it until taken. A gap of zero
	// keeps valid high across the edge, so valid is never dropped and raised
	// again in one step.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
	endtask

	// Build a whole frame and send it. A frame whose header is broken is cut to
	// eighteen bytes, since the receiver closes it there; anything else runs to
	// its terminator, so the next byte is always a fresh start byte.
	task automatic send_frame(input logic [7:0] start_b, input logic [7:0] ver,
			input logic [7:0] addr, input logic [7:0] dev, input logic [7:0] ret,
			input int len, input frame_fault_t fault);
		logic [7:0]  q[$];
		logic [11:0] l12;
		logic [3:0]  s;
		logic [15:0] lw;
		logic [47:0] fields;
		logic [15:0] sum;
		logic [15:0] csum;
		bit          hdr_broken;
		frame_fault_t f;
		int          k;
		f   = fault;
		l12 = len[11:0];
		s   = l12[11:8] + l12[7:4] + l12[3:0];
		lw  = {4'd0 - s, l12};
		if (f == FAULT_LEN_CODE)
			lw[15:12] = lw[15:12] ^ 4'($urandom_range(1, 15));
		fields = {ver, addr, dev, ret, lw};
		q.push_back(start_b);
		for (k = 11; k >= 0; k--)
			q.push_back(hex_char(fields[k*4 +: 4]));
		if (f == FAULT_HDR_CHAR)
			q[$urandom_range(1, 12)] = non_hex();
		if (f == FAULT_NOISE) begin
			q[0] = non_sof();
			for (k = 1; k <= 12; k++)
				q[k] = 8'($urandom_range(0, 255));
		end
		hdr_broken = (q[0] != SOF_CHAR) || ver < VER_MIN || ver > VER_MAX
			|| f == FAULT_HDR_CHAR || f == FAULT_LEN_CODE || f == FAULT_NOISE;
		if (hdr_broken) begin
			repeat (5) q.push_back(8'($urandom_range(0, 255)));
		end else begin
			sum = '0;
			for (k = 1; k <= 12; k++)
				sum = sum + 16'(q[k]);
			for (k = 0; k < len; k++) begin
				q.push_back(hex_char(4'($urandom_range(0, 15))));
				sum = sum + 16'(q[q.size() - 1]);
			end
			if (f == FAULT_BODY_CHAR) begin
				if (len > 0)
					q[13 + $urandom_range(0, len - 1)] = non_hex();
				else
					f = FAULT_SUM_CHAR;
			end
			csum = 16'd0 - sum;
			if (f == FAULT_SUM_VALUE)
				csum = csum ^ 16'($urandom_range(1, 65535));
			for (k = 3; k >= 0; k--)
				q.push_back(hex_char(csum[k*4 +: 4]));
			if (f == FAULT_SUM_CHAR)
				q[q.size() - 1 - $urandom_range(0, 3)] = non_hex();
			// terminator is never checked, so any value will do
			q.push_back($urandom_range(0, 1) ? 8'h0D : 8'($urandom_range(0, 255)));
		end
		foreach (q[i])
			send_byte(q[i]);
	endtask

	// Mostly clean replies with random content; the rest broken in one way.
	task automatic random_frame();
		int           r;
		logic [7:0]   start_b;
		logic [7:0]   ver;
		int           len;
		frame_fault_t fault;
		r       = $urandom_range(0, 99);
		quiet   = ($urandom_range(0, 3) == 0);
		start_b = SOF_CHAR;
		ver     = 8'($urandom_range(8'h20, 8'h2F));
		len     = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 300)
			: $urandom_range(0, 40);
		fault   = FAULT_NONE;
		if (r >= 60 && r < 65)
			ver = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F))
				: 8'($urandom_range(8'h30, 8'hFF));
		else if (r < 70 && r >= 65)
			start_b = non_sof();
		else if (r < 75 && r >= 70)
			fault = FAULT_HDR_CHAR;
		else if (r < 80 && r >= 75)
			fault = FAULT_LEN_CODE;
		else if (r < 86 && r >= 80)
			fault = FAULT_BODY_CHAR;
		else if (r < 90 && r >= 86)
			fault = FAULT_SUM_CHAR;
		else if (r < 96 && r >= 90)
			fault = FAULT_SUM_VALUE;
		else if (r >= 96)
			fault = FAULT_NOISE;
		send_frame(start_b, ver, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			$urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)), len, fault);
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes and each way a frame can go wrong.
		send_frame(SOF_CHAR, 8'h20, 8'h00, 8'h00, 8'h00, 0, FAULT_NONE);
		send_frame(SOF_CHAR, 8'h2F, 8'hFF, 8'hFF, 8'hFF, 1, FAULT_NONE);
		send_frame(SOF_CHAR, 8'h21, 8'hA5, 8'h5A, 8'h00, 16, FAULT_NONE);
		send_frame(SOF_CHAR, 8'h1F, 8'h01, 8'h46, 8'h00, 4, FAULT_NONE);
		send_frame(SOF_CHAR, 8'h30, 8'h01, 8'h46, 8'h00, 4, FAULT_NONE);
		send_frame(8'h00, 8'h20, 8'h01, 8'h46, 8'h00, 4, FAULT_NONE);
		send_frame(8'hFF, 8'h00, 8'h01, 8'h46, 8'h00, 4, FAULT_NONE);
		send_frame(SOF_CHAR, 8'h25, 8'h02, 8'h46, 8'h00, 6, FAULT_HDR_CHAR);
		send_frame(SOF_CHAR, 8'h25, 8'h02, 8'h46, 8'h00, 6, FAULT_LEN_CODE);
		send_frame(SOF_CHAR, 8'hFF, 8'h02, 8'h46, 8'h00, 6, FAULT_LEN_CODE);
		send_frame(SOF_CHAR, 8'h25, 8'h03, 8'h46, 8'h00, 10, FAULT_BODY_CHAR);
		send_frame(SOF_CHAR, 8'h25, 8'h03, 8'h46, 8'h00, 10, FAULT_SUM_CHAR);
		send_frame(SOF_CHAR, 8'h25, 8'h03, 8'h46, 8'h00, 10, FAULT_SUM_VALUE);
		send_frame(SOF_CHAR, 8'h20, 8'h04, 8'h46, 8'h80, 0, FAULT_NOISE);
		// a long info field, run without gaps
		quiet = 1'b1;
		send_frame(SOF_CHAR, 8'h2A, 8'h7F, 8'h80, 8'h01, 300, FAULT_NONE);
		quiet = 1'b0;
		send_frame(SOF_CHAR, 8'h20, 8'h00, 8'h00, 8'h00, 2, FAULT_NONE);

		while (bytes_sent < 760)
			random_frame();

		// Raw bytes to finish: no framing at all, any value at any position.
		quiet = 1'b0;
		repeat (40) send_byte(8'($urandom_range(0, 255)));
		in_valid <= 1'b0;

		// Drain: wait for every predicted word, then let the pipeline settle.
		repeat (2) @(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### bms_ascii_frame_receiver_unit.f
+incdir+rtl/core
rtl/core/bafr_pkg.sv
rtl/core/bms_ascii_frame_receiver_unit.sv
rtl/core/bafr_checker.sv
verif/bms_ascii_frame_receiver_unit_tb.sv
